// File: design/tmu_pkg.sv
// Package for the triangle metrics unit: field widths, lane indexes and
// pipeline depth. No dependencies.
package tmu_pkg;

    // input coordinate, signed Q8.8
    localparam int COORD_W = 16;
    // coordinate difference, one sign bit more
    localparam int DIFF_W = COORD_W + 1;
    // square of a difference, always nonnegative and below 2^32
    localparam int SQ_W = 2 * COORD_W;
    // sum of two squares
    localparam int SUM_W = SQ_W + 1;
    // square-root radicand, padded to an even width
    localparam int RAD_W = SUM_W + (SUM_W % 2);
    // floor root of the radicand
    localparam int ROOT_W = RAD_W / 2;
    // partial remainder of the digit-by-digit root
    localparam int REM_W = ROOT_W + 3;
    // one digit pair per stage
    localparam int SQRT_STAGES = ROOT_W;
    // signed product of two differences
    localparam int PROD_W = 2 * DIFF_W;
    // shoelace determinant
    localparam int DET_W = PROD_W + 1;
    // result fields
    localparam int SIDE_W = 17;
    localparam int PERIM_W = 19;
    localparam int AREA_W = 31;

    localparam int LANES = 3;

    typedef enum logic [1:0] {
        LANE_AB = 2'd0,
        LANE_AC = 2'd1,
        LANE_BC = 2'd2
    } lane_t;

endpackage

// File: design/tmu_channels.sv
// Handshake channels of the triangle metrics unit: vertex beats in,
// metric beats out. Depends on tmu_pkg.
interface tmu_vertex_if;
    logic valid;
    logic ready;
    logic signed [tmu_pkg::COORD_W-1:0] vertex_a_x;
    logic signed [tmu_pkg::COORD_W-1:0] vertex_a_y;
    logic signed [tmu_pkg::COORD_W-1:0] vertex_b_x;
    logic signed [tmu_pkg::COORD_W-1:0] vertex_b_y;
    logic signed [tmu_pkg::COORD_W-1:0] vertex_c_x;
    logic signed [tmu_pkg::COORD_W-1:0] vertex_c_y;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y,
        output ready
    );
endinterface

interface tmu_metric_if;
    logic valid;
    logic ready;
    logic [tmu_pkg::SIDE_W-1:0]  side_ab;
    logic [tmu_pkg::SIDE_W-1:0]  side_ac;
    logic [tmu_pkg::SIDE_W-1:0]  side_bc;
    logic [tmu_pkg::PERIM_W-1:0] perimeter;
    logic [tmu_pkg::AREA_W-1:0]  area;
    logic                        is_triangle;

    modport source (
        output valid, side_ab, side_ac, side_bc, perimeter, area, is_triangle,
        input  ready
    );
    modport sink (
        input  valid, side_ab, side_ac, side_bc, perimeter, area, is_triangle,
        output ready
    );
endinterface

// File: design/triangle_metrics_unit.sv
// Triangle metrics unit: three side lengths, perimeter and shoelace area.
// A vertex beat accepted at an edge moves through the difference, product and
// sum registers, 17 root stages and the output register to its metric beat.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and not taken. Reset clears all valid bits only.
// Depends on tmu_pkg and tmu_channels.
module triangle_metrics_unit (
    input  logic               clk,
    input  logic               rst_n,
    tmu_vertex_if.sink         vertices,
    tmu_metric_if.source       metrics
);

    localparam int NS = tmu_pkg::SQRT_STAGES;
    localparam int NL = tmu_pkg::LANES;

    // Pipeline advance: everything moves together when the output
    // register is empty or being drained this cycle.
    logic adv;

    assign adv            = !metrics.valid || metrics.ready;
    assign vertices.ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: coordinate differences, one pair per side.
    // ------------------------------------------------------------------
    logic                                     s1_valid_reg;
    logic signed [NL-1:0][tmu_pkg::DIFF_W-1:0] s1_dx_reg;
    logic signed [NL-1:0][tmu_pkg::DIFF_W-1:0] s1_dy_reg;

    function automatic logic signed [tmu_pkg::DIFF_W-1:0] diff(
        input logic signed [tmu_pkg::COORD_W-1:0] p,
        input logic signed [tmu_pkg::COORD_W-1:0] q
    );
        diff = $signed({q[tmu_pkg::COORD_W-1], q}) - $signed({p[tmu_pkg::COORD_W-1], p});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= vertices.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg[tmu_pkg::LANE_AB] <= diff(vertices.vertex_a_x, vertices.vertex_b_x);
            s1_dy_reg[tmu_pkg::LANE_AB] <= diff(vertices.vertex_a_y, vertices.vertex_b_y);
            s1_dx_reg[tmu_pkg::LANE_AC] <= diff(vertices.vertex_a_x, vertices.vertex_c_x);
            s1_dy_reg[tmu_pkg::LANE_AC] <= diff(vertices.vertex_a_y, vertices.vertex_c_y);
            s1_dx_reg[tmu_pkg::LANE_BC] <= diff(vertices.vertex_b_x, vertices.vertex_c_x);
            s1_dy_reg[tmu_pkg::LANE_BC] <= diff(vertices.vertex_b_y, vertices.vertex_c_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of every difference and the two cross products
    // of the determinant, (Bx-Ax)(Cy-Ay) and (By-Ay)(Cx-Ax).
    // Elements of a packed array read back unsigned: recast them signed.
    // ------------------------------------------------------------------
    logic                                  s2_valid_reg;
    logic [NL-1:0][tmu_pkg::SQ_W-1:0]      s2_sqx_reg;
    logic [NL-1:0][tmu_pkg::SQ_W-1:0]      s2_sqy_reg;
    logic signed [tmu_pkg::PROD_W-1:0]     s2_p1_reg;
    logic signed [tmu_pkg::PROD_W-1:0]     s2_p2_reg;
    logic [NL-1:0][tmu_pkg::SQ_W-1:0]      s2_sqx_next;
    logic [NL-1:0][tmu_pkg::SQ_W-1:0]      s2_sqy_next;

    always_comb
    begin
        logic signed [tmu_pkg::PROD_W-1:0] px;
        logic signed [tmu_pkg::PROD_W-1:0] py;
        for (int l = 0; l < NL; l++)
        begin
            px = $signed(s1_dx_reg[l]) * $signed(s1_dx_reg[l]);
            py = $signed(s1_dy_reg[l]) * $signed(s1_dy_reg[l]);
            // squares are nonnegative and below 2^32: keep the low bits
            s2_sqx_next[l] = px[tmu_pkg::SQ_W-1:0];
            s2_sqy_next[l] = py[tmu_pkg::SQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sqx_reg <= s2_sqx_next;
            s2_sqy_reg <= s2_sqy_next;
            s2_p1_reg  <= $signed(s1_dx_reg[tmu_pkg::LANE_AB])
                        * $signed(s1_dy_reg[tmu_pkg::LANE_AC]);
            s2_p2_reg  <= $signed(s1_dy_reg[tmu_pkg::LANE_AB])
                        * $signed(s1_dx_reg[tmu_pkg::LANE_AC]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: radicands dx^2 + dy^2 and the determinant. This register
    // is stage 0 of the root chain below.
    // ------------------------------------------------------------------
    logic                              rt_valid_reg [NS+1];
    logic [NL-1:0][tmu_pkg::RAD_W-1:0]  rt_rad_reg   [NS+1];
    logic [NL-1:0][tmu_pkg::REM_W-1:0]  rt_rem_reg   [NS+1];
    logic [NL-1:0][tmu_pkg::ROOT_W-1:0] rt_root_reg  [NS+1];
    logic signed [tmu_pkg::DET_W-1:0]  det_reg;
    // area and flag ride along the root chain from its first stage on
    logic [tmu_pkg::AREA_W-1:0]         sb_area_reg  [1:NS];
    logic                              sb_tri_reg   [1:NS];
    logic [NL-1:0][tmu_pkg::RAD_W-1:0]  s3_rad_next;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            s3_rad_next[l] = tmu_pkg::RAD_W'({1'b0, s2_sqx_reg[l]})
                           + tmu_pkg::RAD_W'({1'b0, s2_sqy_reg[l]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            rt_valid_reg[0] <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt_rad_reg[0]  <= s3_rad_next;
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            det_reg        <= $signed({s2_p1_reg[tmu_pkg::PROD_W-1], s2_p1_reg})
                            - $signed({s2_p2_reg[tmu_pkg::PROD_W-1], s2_p2_reg});
        end
    end

    // ------------------------------------------------------------------
    // Root chain: one result bit per stage, restoring digit-by-digit
    // floor square root, three lanes side by side.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < NS; j++)
    begin : g_root
        logic [NL-1:0][tmu_pkg::RAD_W-1:0]  rad_next;
        logic [NL-1:0][tmu_pkg::REM_W-1:0]  rem_next;
        logic [NL-1:0][tmu_pkg::ROOT_W-1:0] root_next;
        logic [tmu_pkg::AREA_W-1:0]         area_next;
        logic                               tri_next;

        always_comb
        begin
            logic [tmu_pkg::REM_W-1:0] rem_sh;
            logic [tmu_pkg::REM_W-1:0] trial;
            for (int l = 0; l < NL; l++)
            begin
                rem_sh = {rt_rem_reg[j][l][tmu_pkg::REM_W-3:0],
                          rt_rad_reg[j][l][tmu_pkg::RAD_W-1:tmu_pkg::RAD_W-2]};
                trial  = {1'b0, rt_root_reg[j][l], 2'b01};
                rad_next[l] = {rt_rad_reg[j][l][tmu_pkg::RAD_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next[l]  = rem_sh - trial;
                    root_next[l] = {rt_root_reg[j][l][tmu_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l]  = rem_sh;
                    root_next[l] = {rt_root_reg[j][l][tmu_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end

        if (j == 0)
        begin : g_area
            // magnitude of the determinant, halved and floored
            always_comb
            begin
                logic [tmu_pkg::DET_W-1:0] mag;
                mag       = det_reg[tmu_pkg::DET_W-1] ? tmu_pkg::DET_W'(-det_reg)
                                                      : tmu_pkg::DET_W'(det_reg);
                area_next = mag[tmu_pkg::AREA_W:1];
                tri_next  = |det_reg;
            end
        end
        else
        begin : g_carry
            assign area_next = sb_area_reg[j];
            assign tri_next  = sb_tri_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                rt_valid_reg[j+1] <= rt_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_rad_reg[j+1]  <= rad_next;
                rt_rem_reg[j+1]  <= rem_next;
                rt_root_reg[j+1] <= root_next;
                sb_area_reg[j+1] <= area_next;
                sb_tri_reg[j+1]  <= tri_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: sides, perimeter, area and the triangle flag.
    // ------------------------------------------------------------------
    logic                          out_valid_reg;
    logic [tmu_pkg::SIDE_W-1:0]    side_ab_reg;
    logic [tmu_pkg::SIDE_W-1:0]    side_ac_reg;
    logic [tmu_pkg::SIDE_W-1:0]    side_bc_reg;
    logic [tmu_pkg::PERIM_W-1:0]   perimeter_reg;
    logic [tmu_pkg::AREA_W-1:0]    area_reg;
    logic                          is_triangle_reg;
    logic [tmu_pkg::PERIM_W-1:0]   perimeter_next;

    assign perimeter_next = tmu_pkg::PERIM_W'(rt_root_reg[NS][tmu_pkg::LANE_AB])
                          + tmu_pkg::PERIM_W'(rt_root_reg[NS][tmu_pkg::LANE_AC])
                          + tmu_pkg::PERIM_W'(rt_root_reg[NS][tmu_pkg::LANE_BC]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= rt_valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_ab_reg     <= tmu_pkg::SIDE_W'(rt_root_reg[NS][tmu_pkg::LANE_AB]);
            side_ac_reg     <= tmu_pkg::SIDE_W'(rt_root_reg[NS][tmu_pkg::LANE_AC]);
            side_bc_reg     <= tmu_pkg::SIDE_W'(rt_root_reg[NS][tmu_pkg::LANE_BC]);
            perimeter_reg   <= perimeter_next;
            area_reg        <= sb_area_reg[NS];
            is_triangle_reg <= sb_tri_reg[NS];
        end
    end

    assign metrics.valid       = out_valid_reg;
    assign metrics.side_ab     = side_ab_reg;
    assign metrics.side_ac     = side_ac_reg;
    assign metrics.side_bc     = side_bc_reg;
    assign metrics.perimeter   = perimeter_reg;
    assign metrics.area        = area_reg;
    assign metrics.is_triangle = is_triangle_reg;

`ifndef SYNTH
    // collinear vertices have no area
    a_flat_no_area: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_triangle_reg) |-> (area_reg == '0))
        else $error("area nonzero for collinear vertices");

    // a real triangle has distinct vertices, so no zero side
    a_tri_sides: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_triangle_reg) |->
            (side_ab_reg != '0 && side_ac_reg != '0 && side_bc_reg != '0))
        else $error("zero side on a nondegenerate triangle");

    // floored side bc stays within one lsb of the sum of the other two sides
    a_tri_ineq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ({2'b00, side_bc_reg} <= {1'b0, side_ab_reg} + {1'b0, side_ac_reg} + 19'd1))
        else $error("side lengths violate the triangle inequality");

    // a beat leaving the root chain lands in the output register
    a_chain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && rt_valid_reg[NS]) |=> out_valid_reg)
        else $error("beat lost between root chain and output");
`endif

endmodule

// File: bench/triangle_metrics_unit_test.sv
// Testbench for triangle_metrics_unit: vertex beats in, metric beats out,
// each metric beat checked against a predictor kept in the bench.
// Depends on tmu_pkg, tmu_channels and the triangle_metrics_unit RTL.
module triangle_metrics_unit_test;

    // Pipeline depth of the RTL, plus margin for the final wait.
    localparam int PIPE_LATENCY = 21;
    localparam int DRAIN_TAIL = PIPE_LATENCY + 8;
    // Cycles with no beat on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the deliberate output hold-off.
    localparam int LONG_HOLD = 64;
    localparam int RANDOM_SEGMENTS = 8;
    localparam int SEGMENT_BEATS = 88;
    localparam int PRESSURE_BEATS = 80;

    typedef logic signed [tmu_pkg::COORD_W-1:0] coord_t;

    typedef struct {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
    } triangle_t;

    typedef struct {
        logic [tmu_pkg::SIDE_W-1:0]  side_ab;
        logic [tmu_pkg::SIDE_W-1:0]  side_ac;
        logic [tmu_pkg::SIDE_W-1:0]  side_bc;
        logic [tmu_pkg::PERIM_W-1:0] perimeter;
        logic [tmu_pkg::AREA_W-1:0]  area;
        logic                        is_triangle;
    } metrics_t;

    logic clk = 1'b0;
    logic rst_n;

    tmu_vertex_if vtx ();
    tmu_metric_if met ();

    triangle_metrics_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .vertices (vtx),
        .metrics  (met)
    );

    // Metrics predicted for accepted vertex beats, oldest first.
    metrics_t pending_metrics[$];
    int       mismatch_count = 0;

    // Idle controls shared between the stimulus and the metric sink.
    bit sender_steady = 1'b0;   // no gaps between vertex beats
    bit sink_steady = 1'b0;     // ready held high
    bit hold_request = 1'b0;    // ask the sink for one long hold-off

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Floor square root, two bits of radicand per step.
    function automatic longint unsigned floor_root(longint unsigned radicand);
        longint unsigned remainder;
        longint unsigned root;
        longint unsigned place;
        remainder = radicand;
        root = 0;
        place = 64'd1 << 62;
        while (place > remainder)
            place = place >> 2;
        while (place != 0)
        begin
            if (remainder >= root + place)
            begin
                remainder = remainder - (root + place);
                root = (root >> 1) + place;
            end
            else
            begin
                root = root >> 1;
            end
            place = place >> 2;
        end
        return root;
    endfunction

    // Squares of Q8.8 differences are exact Q16.16, so the root is Q8.8.
    function automatic longint unsigned edge_length(coord_t x0, coord_t y0,
                                                    coord_t x1, coord_t y1);
        longint dx;
        longint dy;
        dx = longint'(x1) - longint'(x0);
        dy = longint'(y1) - longint'(y0);
        return floor_root(longint'(dx * dx) + longint'(dy * dy));
    endfunction

    function automatic metrics_t predict_metrics(triangle_t t);
        metrics_t        m;
        longint unsigned len_ab;
        longint unsigned len_ac;
        longint unsigned len_bc;
        longint          det;
        longint unsigned det_mag;
        len_ab = edge_length(t.ax, t.ay, t.bx, t.by);
        len_ac = edge_length(t.ax, t.ay, t.cx, t.cy);
        len_bc = edge_length(t.bx, t.by, t.cx, t.cy);
        // Shoelace determinant, exact in Q16.16.
        det = (longint'(t.bx) - longint'(t.ax)) * (longint'(t.cy) - longint'(t.ay))
            - (longint'(t.by) - longint'(t.ay)) * (longint'(t.cx) - longint'(t.ax));
        det_mag = (det < 0) ? longint'(-det) : longint'(det);
        m.side_ab = len_ab[tmu_pkg::SIDE_W-1:0];
        m.side_ac = len_ac[tmu_pkg::SIDE_W-1:0];
        m.side_bc = len_bc[tmu_pkg::SIDE_W-1:0];
        m.perimeter = tmu_pkg::PERIM_W'(len_ab + len_ac + len_bc);
        // Halve with floor: the low bit of an odd determinant is dropped.
        m.area = tmu_pkg::AREA_W'(det_mag >> 1);
        m.is_triangle = (det != 0);
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic triangle_t make_triangle(int ax, int ay, int bx, int by,
                                                int cx, int cy);
        triangle_t t;
        t.ax = coord_t'(ax);
        t.ay = coord_t'(ay);
        t.bx = coord_t'(bx);
        t.by = coord_t'(by);
        t.cx = coord_t'(cx);
        t.cy = coord_t'(cy);
        return t;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic coord_t pick_edge_value();
        case ($urandom_range(0, 4))
            0: return coord_t'(-32768);
            1: return coord_t'(32767);
            2: return coord_t'(0);
            3: return coord_t'(-1);
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic triangle_t random_triangle();
        triangle_t t;
        int        base_x;
        int        base_y;
        int        step_x;
        int        step_y;
        int        scale;
        case ($urandom_range(0, 9))
            5, 6:
            begin
                // Collinear: C lies on the line through A and B.
                base_x = int'($urandom_range(0, 32000)) - 16000;
                base_y = int'($urandom_range(0, 32000)) - 16000;
                step_x = int'($urandom_range(0, 2000)) - 1000;
                step_y = int'($urandom_range(0, 2000)) - 1000;
                scale = int'($urandom_range(0, 16)) - 8;
                t = make_triangle(base_x, base_y, base_x + step_x, base_y + step_y,
                                  base_x + scale * step_x, base_y + scale * step_y);
            end
            7:
            begin
                t.ax = pick_edge_value();
                t.ay = pick_edge_value();
                t.bx = pick_edge_value();
                t.by = pick_edge_value();
                t.cx = pick_edge_value();
                t.cy = pick_edge_value();
            end
            8:
            begin
                // Tight triangle: tiny areas, odd determinants are common.
                base_x = int'($urandom_range(0, 64000)) - 32000;
                base_y = int'($urandom_range(0, 64000)) - 32000;
                t = make_triangle(base_x, base_y,
                                  base_x + int'($urandom_range(0, 600)) - 300,
                                  base_y + int'($urandom_range(0, 600)) - 300,
                                  base_x + int'($urandom_range(0, 600)) - 300,
                                  base_y + int'($urandom_range(0, 600)) - 300);
            end
            9:
            begin
                // Coincident vertices.
                t.ax = coord_t'($urandom());
                t.ay = coord_t'($urandom());
                t.cx = coord_t'($urandom());
                t.cy = coord_t'($urandom());
                if ($urandom_range(0, 1))
                begin
                    t.bx = t.ax;
                    t.by = t.ay;
                end
                else
                begin
                    t.bx = t.cx;
                    t.by = t.cy;
                end
            end
            default:
            begin
                t.ax = coord_t'($urandom());
                t.ay = coord_t'($urandom());
                t.bx = coord_t'($urandom());
                t.by = coord_t'($urandom());
                t.cx = coord_t'($urandom());
                t.cy = coord_t'($urandom());
            end
        endcase
        return t;
    endfunction

    // Offer one vertex beat and hold it until accepted. Entered and left at
    // a rising edge; the predicted metrics are queued on the accepting edge.
    task automatic send_triangle(input triangle_t t);
        int gap;
        gap = sender_steady ? 0 : draw_gap();
        if (gap > 0)
        begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vtx.valid <= 1'b1;
        vtx.vertex_a_x <= t.ax;
        vtx.vertex_a_y <= t.ay;
        vtx.vertex_b_x <= t.bx;
        vtx.vertex_b_y <= t.by;
        vtx.vertex_c_x <= t.cx;
        vtx.vertex_c_y <= t.cy;
        do
            @(posedge clk);
        while (!vtx.ready);
        pending_metrics.push_back(predict_metrics(t));
    endtask

    // Drop valid and wait until every predicted beat has come back.
    // Always advance at least one edge so the next valid is a fresh drive.
    task automatic wait_for_drain();
        vtx.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_metrics.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners of the coordinate range: largest sides, largest area in both
    // orientations, all-equal vertices and alternating bit patterns.
    task automatic test_extreme_coordinates();
        triangle_t cases[$];
        cases.push_back(make_triangle(0, 0, 0, 0, 0, 0));
        cases.push_back(make_triangle(32767, 32767, 32767, 32767, 32767, 32767));
        cases.push_back(make_triangle(-32768, -32768, -32768, -32768, -32768, -32768));
        cases.push_back(make_triangle(-32768, -32768, 32767, 32767, -32768, 32767));
        cases.push_back(make_triangle(32767, -32768, -32768, 32767, 32767, 32767));
        cases.push_back(make_triangle(-32768, -32768, 32767, -32768, -32768, 32767));
        cases.push_back(make_triangle(-32768, -32768, -32768, 32767, 32767, -32768));
        cases.push_back(make_triangle(32767, 32767, -32768, 32767, 32767, -32768));
        cases.push_back(make_triangle(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                                      16'h5555, 16'h5555));
        cases.push_back(make_triangle(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                                      16'hAAAA, 16'hAAAA));
        foreach (cases[i])
            send_triangle(cases[i]);
        wait_for_drain();
    endtask

    // Collinear and coincident vertices: no area, sides still reported.
    task automatic test_degenerate_triangles();
        triangle_t cases[$];
        cases.push_back(make_triangle(100, 200, 100, 200, 100, 200));
        cases.push_back(make_triangle(-500, 300, 1000, 300, 32767, 300));
        cases.push_back(make_triangle(-700, -32768, -700, 0, -700, 32767));
        cases.push_back(make_triangle(-32768, -32768, 0, 0, 32767, 32767));
        cases.push_back(make_triangle(1234, -4321, 900, 77, 900, 77));
        cases.push_back(make_triangle(256, 512, 768, 1536, -256, -512));
        foreach (cases[i])
            send_triangle(cases[i]);
        wait_for_drain();
    endtask

    // Odd determinants of both signs, plus one even one: the halving must floor the magnitude.
    task automatic test_odd_determinants();
        triangle_t cases[$];
        cases.push_back(make_triangle(0, 0, 1, 0, 0, 1));
        cases.push_back(make_triangle(0, 0, 0, 1, 1, 0));
        cases.push_back(make_triangle(0, 0, 1, 0, 1, 3));
        cases.push_back(make_triangle(0, 0, 1, 3, 1, 0));
        cases.push_back(make_triangle(0, 0, 256, 0, 0, 256));
        cases.push_back(make_triangle(-3, 5, -2, 5, -3, 4));
        foreach (cases[i])
            send_triangle(cases[i]);
        wait_for_drain();
    endtask

    // Hold the output off for a long stretch while vertex beats keep coming,
    // so the pipeline fills and stalls its input; then drain completely.
    task automatic test_output_backpressure();
        sender_steady = 1'b1;
        hold_request = 1'b1;
        repeat (PRESSURE_BEATS)
            send_triangle(random_triangle());
        wait_for_drain();
        sender_steady = 1'b0;
    endtask

    // Long random run, alternating stretches with and without idling, with
    // one full pause midway.
    task automatic test_random_stream();
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            sender_steady = (seg % 3 == 0);
            sink_steady = (seg % 4 == 1);
            repeat (SEGMENT_BEATS)
                send_triangle(random_triangle());
            if (seg == RANDOM_SEGMENTS / 2)
                wait_for_drain();
        end
        wait_for_drain();
        sender_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Metric sink: random ready, one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : metric_sink
        int idle_left;
        idle_left = 0;
        met.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                met.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                met.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_left > 0)
            begin
                met.ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                met.ready <= 1'b1;
                idle_left = sink_steady ? 0 : draw_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Metric checker
    // ------------------------------------------------------------------

    function automatic void check_field(string label, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && met.valid && met.ready)
        begin
            if (pending_metrics.size() == 0)
            begin
                $display("%0t: unexpected metric beat, expected none, actual area %0d",
                         $time, met.area);
                mismatch_count++;
            end
            else
            begin
                metrics_t want;
                want = pending_metrics.pop_front();
                check_field("side_ab", want.side_ab, met.side_ab);
                check_field("side_ac", want.side_ac, met.side_ac);
                check_field("side_bc", want.side_bc, met.side_bc);
                check_field("perimeter", want.perimeter, met.perimeter);
                check_field("area", want.area, met.area);
                check_field("is_triangle", want.is_triangle, met.is_triangle);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count edges with no beat on either channel
    // ------------------------------------------------------------------

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (vtx.valid && vtx.ready) || (met.valid && met.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** triangle_metrics_unit: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n <= 1'b0;
        vtx.valid <= 1'b0;
        vtx.vertex_a_x <= '0;
        vtx.vertex_a_y <= '0;
        vtx.vertex_b_x <= '0;
        vtx.vertex_b_y <= '0;
        vtx.vertex_c_x <= '0;
        vtx.vertex_c_y <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_extreme_coordinates();
        test_degenerate_triangles();
        test_odd_determinants();
        test_output_backpressure();
        test_random_stream();

        // Catch any stray beat after the last expected one.
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatch_count == 0 && pending_metrics.size() == 0)
            $display("** triangle_metrics_unit: PASSED **");
        else
            $display("** triangle_metrics_unit: FAILED **");
        $finish;
    end

endmodule

// File: files.f
design/tmu_pkg.sv
design/tmu_channels.sv
design/triangle_metrics_unit.sv
bench/triangle_metrics_unit_test.sv
